// ===== rtl/dmarb_pkg.sv =====
// ----------------------------------------------------------------------------
// dmarb_pkg
// Shared types and constants of the distributed mutex arbiter: message and
// operation codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package dmarb_pkg;

  // Default number of peers; the deferred store never exceeds 2**PeerIdW ids
  localparam int unsigned MaxPeersDefault = 16;

  localparam int unsigned PeerIdW  = 4;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned MaskW    = 16;
  localparam int unsigned ReqTypeW = 3;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Operation carried by an input beat
  typedef enum logic [ReqTypeW-1:0] {
    REQ_REMOTE_REQUEST = 3'd0,
    REQ_REMOTE_REPLY   = 3'd1,
    REQ_REMOTE_OTHER   = 3'd2,
    REQ_LOCAL_LOCK     = 3'd3,
    REQ_LOCAL_UNLOCK   = 3'd4
  } req_type_e;

  // Kind of an output beat
  typedef enum logic [KindW-1:0] {
    KIND_REQUEST = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_GRANT   = 2'd2,
    KIND_ERROR   = 2'd3
  } msg_kind_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_OWN_NODE_ID = 2'd0,
    CFG_PEER_MASK   = 2'd1
  } cfg_reg_e;

endpackage

// ===== rtl/dmarb_ram.sv =====
// ----------------------------------------------------------------------------
// dmarb_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered. Contents are undefined at reset.
// ----------------------------------------------------------------------------
module dmarb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/distributed_mutex_arbiter.sv =====
// ----------------------------------------------------------------------------
// distributed_mutex_arbiter
// One node of a Ricart-Agrawala distributed lock kept in step by a 32-bit
// wrapping Lamport clock.
//
// Input channel (in_valid_i/in_ready_o) takes one operation a beat: remote
// request, remote reply, other remote message, local lock or local unlock.
// Output channel (out_valid_o/out_ready_i) gives zero or more message beats
// per operation; last_o marks the final beat of an operation.
// Config channel (cfg_valid_i/cfg_ready_o) writes own_node_id and peer_mask;
// always ready. The user writes it only while idle; the block does not check.
//
// An operation passes through accept, clock update and execute. Its first
// result lands in the output register at the end of the execute step. A lock
// with an empty peer mask adds a grant state for the grant beat. An unlock
// walks the deferred-time RAM once per deferred reply: a scan through the
// single read port, then an emit state.
// The next operation is accepted while the last result still waits in the
// output register; a stalled receiver holds the sequencer before it emits.
// Reset clears clock, pending lock, deferred and outstanding bits at once;
// the deferred-time RAM is not cleared, its entries are read only when valid.
// ----------------------------------------------------------------------------
module distributed_mutex_arbiter #(
  parameter int unsigned MAX_PEERS = dmarb_pkg::MaxPeersDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dmarb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dmarb_pkg::CfgDataW-1:0]  cfg_data_i,
  // operations
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [dmarb_pkg::ReqTypeW-1:0]  req_type_i,
  input  logic [dmarb_pkg::PeerIdW-1:0]   peer_id_i,
  input  logic [dmarb_pkg::TimeW-1:0]     remote_time_i,
  // messages
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dmarb_pkg::KindW-1:0]     msg_kind_o,
  output logic [dmarb_pkg::PeerIdW-1:0]   dest_peer_o,
  output logic [dmarb_pkg::TimeW-1:0]     timestamp_o,
  output logic                            last_o
);

  import dmarb_pkg::*;

  localparam int unsigned NUM_SLOTS = (MAX_PEERS < (1 << PeerIdW)) ? MAX_PEERS
                                                                    : (1 << PeerIdW);
  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);

  localparam logic [PeerIdW:0]     PeerLimit = (PeerIdW + 1)'(NUM_SLOTS);
  localparam logic [CNT_W-1:0]     CntLimit  = CNT_W'(NUM_SLOTS);
  localparam logic [NUM_SLOTS-1:0] SlotOne   = NUM_SLOTS'(1);
  localparam logic [TimeW-1:0]     TimeOne   = TimeW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOCK,
    S_EXEC,
    S_GRANT,
    S_SCAN,
    S_EMIT
  } state_e;

  // true when (ta, ia) is strictly larger than (tb, ib)
  function automatic logic pair_greater(logic [TimeW-1:0] ta, logic [PeerIdW-1:0] ia,
                                        logic [TimeW-1:0] tb, logic [PeerIdW-1:0] ib);
    logic res;
    if (ta != tb) begin
      res = ta > tb;
    end else begin
      res = ia > ib;
    end
    return res;
  endfunction

  // Control and node state
  state_e                 state_q, state_d;
  logic [PeerIdW-1:0]     own_id_q, own_id_d;
  logic [MaskW-1:0]       peer_mask_q, peer_mask_d;
  logic [TimeW-1:0]       clock_q, clock_d;
  logic                   pending_q, pending_d;
  logic [TimeW-1:0]       req_time_q, req_time_d;
  logic [NUM_SLOTS-1:0]   defer_vld_q, defer_vld_d;
  logic [NUM_SLOTS-1:0]   outstand_q, outstand_d;

  // Captured operation
  req_type_e              op_type_q, op_type_d;
  logic [PeerIdW-1:0]     op_peer_q, op_peer_d;
  logic [TimeW-1:0]       op_time_q, op_time_d;

  // Minimum search over the deferred store
  logic [CNT_W-1:0]       scan_cnt_q, scan_cnt_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic [SLOT_W-1:0]      cmp_idx_q, cmp_idx_d;
  logic                   best_found_q, best_found_d;
  logic [SLOT_W-1:0]      best_idx_q, best_idx_d;
  logic [TimeW-1:0]       best_time_q, best_time_d;

  // Output register
  logic                   out_valid_q, out_valid_d;
  msg_kind_e              out_kind_q, out_kind_d;
  logic [PeerIdW-1:0]     out_dest_q, out_dest_d;
  logic [TimeW-1:0]       out_ts_q, out_ts_d;
  logic                   out_last_q, out_last_d;

  // Deferred-time RAM ports
  logic                   ram_we, ram_re;
  logic [SLOT_W-1:0]      ram_waddr, ram_raddr;
  logic [TimeW-1:0]       ram_rdata;

  logic                   out_free;
  logic                   peer_ok;
  logic [SLOT_W-1:0]      peer_idx;
  logic [NUM_SLOTS-1:0]   outstand_clr;
  logic [NUM_SLOTS-1:0]   defer_left;
  logic [TimeW-1:0]       clock_inc;

  dmarb_ram #(
    .Width (TimeW),
    .Depth (NUM_SLOTS)
  ) u_defer_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (op_time_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  assign out_free     = !out_valid_q || out_ready_i;
  assign peer_ok      = {1'b0, op_peer_q} < PeerLimit;
  assign peer_idx     = op_peer_q[SLOT_W-1:0];
  assign outstand_clr = outstand_q & ~(SlotOne << peer_idx);
  assign defer_left   = defer_vld_q & ~(SlotOne << best_idx_q);
  assign clock_inc    = clock_q + TimeOne;
  assign ram_waddr    = peer_idx;
  assign ram_raddr    = scan_cnt_q[SLOT_W-1:0];

  // Sequence one operation through clock update, execute and scan
  always_comb begin
    state_d      = state_q;
    own_id_d     = own_id_q;
    peer_mask_d  = peer_mask_q;
    clock_d      = clock_q;
    pending_d    = pending_q;
    req_time_d   = req_time_q;
    defer_vld_d  = defer_vld_q;
    outstand_d   = outstand_q;
    op_type_d    = op_type_q;
    op_peer_d    = op_peer_q;
    op_time_d    = op_time_q;
    scan_cnt_d   = scan_cnt_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_time_d  = best_time_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_dest_d   = out_dest_q;
    out_ts_d     = out_ts_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    // Register writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OWN_NODE_ID: own_id_d    = cfg_data_i[PeerIdW-1:0];
        CFG_PEER_MASK:   peer_mask_d = cfg_data_i[MaskW-1:0];
        default:         ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_type_d = req_type_e'(req_type_i);
          op_peer_d = peer_id_i;
          op_time_d = remote_time_i;
          state_d   = S_CLOCK;
        end
      end

      // Raise the clock past any remote timestamp
      S_CLOCK: begin
        case (op_type_q)
          REQ_REMOTE_REQUEST, REQ_REMOTE_REPLY, REQ_REMOTE_OTHER: begin
            clock_d = ((op_time_q > clock_q) ? op_time_q : clock_q) + TimeOne;
          end
          default: ;
        endcase
        state_d = S_EXEC;
      end

      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
          case (op_type_q)
            REQ_REMOTE_REQUEST: begin
              if (!pending_q || !peer_ok ||
                  pair_greater(req_time_q, own_id_q, op_time_q, op_peer_q)) begin
                clock_d     = clock_inc;
                out_valid_d = 1'b1;
                out_kind_d  = KIND_REPLY;
                out_dest_d  = op_peer_q;
                out_ts_d    = clock_inc;
                out_last_d  = 1'b1;
              end else begin
                ram_we                = 1'b1;
                defer_vld_d[peer_idx] = 1'b1;
              end
            end
            REQ_REMOTE_REPLY: begin
              if (peer_ok) begin
                outstand_d = outstand_clr;
                if (pending_q && outstand_q[peer_idx] && outstand_clr == '0) begin
                  out_valid_d = 1'b1;
                  out_kind_d  = KIND_GRANT;
                  out_dest_d  = '0;
                  out_ts_d    = '0;
                  out_last_d  = 1'b1;
                end
              end
            end
            REQ_LOCAL_LOCK: begin
              out_valid_d = 1'b1;
              out_dest_d  = '0;
              if (pending_q) begin
                out_kind_d = KIND_ERROR;
                out_ts_d   = '0;
                out_last_d = 1'b1;
              end else begin
                clock_d    = clock_inc;
                req_time_d = clock_inc;
                pending_d  = 1'b1;
                outstand_d = peer_mask_q[NUM_SLOTS-1:0];
                out_kind_d = KIND_REQUEST;
                out_ts_d   = clock_inc;
                out_last_d = (peer_mask_q[NUM_SLOTS-1:0] != '0);
                if (peer_mask_q[NUM_SLOTS-1:0] == '0) begin
                  state_d = S_GRANT;
                end
              end
            end
            REQ_LOCAL_UNLOCK: begin
              if (defer_vld_q != '0) begin
                state_d      = S_SCAN;
                scan_cnt_d   = '0;
                cmp_vld_d    = 1'b0;
                best_found_d = 1'b0;
              end else begin
                pending_d  = 1'b0;
                outstand_d = '0;
              end
            end
            default: ;
          endcase
        end
      end

      // Grant straight after a request with no peers to wait for
      S_GRANT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_GRANT;
          out_dest_d  = '0;
          out_ts_d    = '0;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      // Read one slot a cycle, compare the slot read last cycle
      S_SCAN: begin
        if (cmp_vld_q && (!best_found_q || ram_rdata < best_time_q)) begin
          best_found_d = 1'b1;
          best_idx_d   = cmp_idx_q;
          best_time_d  = ram_rdata;
        end
        if (scan_cnt_q < CntLimit) begin
          ram_re     = 1'b1;
          cmp_vld_d  = defer_vld_q[scan_cnt_q[SLOT_W-1:0]];
          cmp_idx_d  = scan_cnt_q[SLOT_W-1:0];
          scan_cnt_d = scan_cnt_q + CNT_W'(1);
        end else begin
          cmp_vld_d = 1'b0;
          state_d   = S_EMIT;
        end
      end

      // Send the reply to the oldest deferred request, then rescan or finish
      S_EMIT: begin
        if (out_free) begin
          defer_vld_d = defer_left;
          clock_d     = clock_inc;
          out_valid_d = 1'b1;
          out_kind_d  = KIND_REPLY;
          out_dest_d  = PeerIdW'(best_idx_q);
          out_ts_d    = clock_inc;
          out_last_d  = (defer_left == '0);
          if (defer_left == '0) begin
            pending_d  = 1'b0;
            outstand_d = '0;
            state_d    = S_IDLE;
          end else begin
            scan_cnt_d   = '0;
            best_found_d = 1'b0;
            state_d      = S_SCAN;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      own_id_q     <= '0;
      peer_mask_q  <= '0;
      clock_q      <= '0;
      pending_q    <= 1'b0;
      req_time_q   <= '0;
      defer_vld_q  <= '0;
      outstand_q   <= '0;
      scan_cnt_q   <= '0;
      cmp_vld_q    <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_REQUEST;
      out_dest_q   <= '0;
      out_ts_q     <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      own_id_q     <= own_id_d;
      peer_mask_q  <= peer_mask_d;
      clock_q      <= clock_d;
      pending_q    <= pending_d;
      req_time_q   <= req_time_d;
      defer_vld_q  <= defer_vld_d;
      outstand_q   <= outstand_d;
      scan_cnt_q   <= scan_cnt_d;
      cmp_vld_q    <= cmp_vld_d;
      best_found_q <= best_found_d;
      out_valid_q  <= out_valid_d;
      out_kind_q   <= out_kind_d;
      out_dest_q   <= out_dest_d;
      out_ts_q     <= out_ts_d;
      out_last_q   <= out_last_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_type_q   <= op_type_d;
    op_peer_q   <= op_peer_d;
    op_time_q   <= op_time_d;
    cmp_idx_q   <= cmp_idx_d;
    best_idx_q  <= best_idx_d;
    best_time_q <= best_time_d;
  end

  assign out_valid_o = out_valid_q;
  assign msg_kind_o  = out_kind_q;
  assign dest_peer_o = out_dest_q;
  assign timestamp_o = out_ts_q;
  assign last_o      = out_last_q;

  // Deferred replies exist only behind a pending local request
  a_defer_needs_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (defer_vld_q != '0) |-> pending_q)
    else $error("deferred entry without pending lock");

  // Outstanding replies exist only behind a pending local request
  a_outstand_needs_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outstand_q != '0) |-> pending_q)
    else $error("outstanding reply without pending lock");

  // A scan always finds a valid entry before emitting
  a_emit_has_best : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> best_found_q)
    else $error("reply emitted without a selected entry");

  // Taking the lock always puts the broadcast request in the output register
  a_lock_sends_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pending_q) |-> (out_valid_q && out_kind_q == KIND_REQUEST))
    else $error("lock taken without request beat");

endmodule
